/* src/ltg_pkg.sv */
// Package for the life tile generation unit.
// Holds cell and operation codes, the controller state type and the sweep tap struct.
// No dependencies.
package ltg_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int DIM_W    = 7;
    localparam int MIN_DIM  = 5;

    typedef logic [1:0] cell_t;
    typedef cell_t [4:0] ltg_col_t;

    localparam cell_t CELL_DEAD   = 2'd0;
    localparam cell_t CELL_LIVE   = 2'd1;
    localparam cell_t CELL_UNDEF  = 2'd2;
    localparam cell_t CELL_BORDER = 2'd3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_GEN   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic REG_GRID_HEIGHT = 1'b0;
    localparam logic REG_GRID_WIDTH  = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_GEN,
        ST_GEN_END,
        ST_COPY,
        ST_COPY_END
    } ltg_state_t;

    // Tag of one sweep read on its way back from the cell memory.
    typedef struct packed {
        logic             valid;
        logic [2:0]       k;
        logic [ROW_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             mask;
    } ltg_tap_t;

    // Clamp a dimension register to the usable range.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(MIN_DIM)) r = DIM_W'(MIN_DIM);
        if (v > DIM_W'(hi)) r = DIM_W'(hi);
        return r;
    endfunction

endpackage

/* src/ltg_in_if.sv */
// Input channel of the life tile generation unit.
// Depends on ltg_pkg.
interface ltg_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [ltg_pkg::ROW_W-1:0] row;
    logic [ltg_pkg::COL_W-1:0] col;
    logic [1:0]               cell_value;

    modport source (output valid, op, row, col, cell_value, input ready);
    modport sink (input valid, op, row, col, cell_value, output ready);
endinterface

/* src/ltg_out_if.sv */
// Output channel of the life tile generation unit.
// No dependencies.
interface ltg_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] read_value;
    logic       resize_request;

    modport source (output valid, read_value, resize_request, input ready);
    modport sink (input valid, read_value, resize_request, output ready);
endinterface

/* src/ltg_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ltg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/ltg_window.sv */
// Sliding 5x5 window over the sweep read stream; applies B3/S23 and the resize test.
// Depends on ltg_pkg.
module ltg_window (
    input  logic                          clk,
    input  ltg_pkg::ltg_tap_t             tap,
    input  ltg_pkg::cell_t                rdata,
    input  logic [ltg_pkg::DIM_W-1:0]     eff_h,
    input  logic [ltg_pkg::DIM_W-1:0]     eff_w,
    output logic                          nx_we,
    output logic [ltg_pkg::ADDR_W-1:0]    nx_addr,
    output ltg_pkg::cell_t                nx_wdata,
    output logic                          hit
);
    import ltg_pkg::*;

    cell_t    part_reg [4];
    ltg_col_t win_reg [4];
    ltg_col_t new_col;
    cell_t    cval;
    cell_t    center;
    logic [DIM_W-1:0] c;
    logic [DIM_W-1:0] r;
    logic [3:0] n;
    logic ring;
    logic undef_near;
    logic eval;

    assign cval = tap.mask ? rdata : CELL_DEAD;

    // Column being completed by the current return.
    always_comb
    begin
        new_col[0] = part_reg[0];
        new_col[1] = part_reg[1];
        new_col[2] = part_reg[2];
        new_col[3] = part_reg[3];
        new_col[4] = cval;
    end

    // Collect column parts and shift the window when a column is complete.
    always_ff @(posedge clk)
    begin
        if (tap.valid)
        begin
            if (tap.k == 3'd4)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= win_reg[3];
                win_reg[3] <= new_col;
            end
            else
            begin
                part_reg[tap.k[1:0]] <= cval;
            end
        end
    end

    // Rule evaluation on the full window; window column i is cell column c-2+i.
    always_comb
    begin
        ltg_col_t w [5];
        w[0] = win_reg[0];
        w[1] = win_reg[1];
        w[2] = win_reg[2];
        w[3] = win_reg[3];
        w[4] = new_col;
        c = tap.col - DIM_W'(2);
        r = {1'b0, tap.row};
        center = w[2][2];
        n = 4'd0;
        for (int i = 1; i <= 3; i++)
        begin
            for (int k = 1; k <= 3; k++)
            begin
                if (!(i == 2 && k == 2) && w[i][k] == CELL_LIVE)
                begin
                    n = n + 4'd1;
                end
            end
        end
        undef_near = 1'b0;
        for (int i = 0; i <= 4; i += 2)
        begin
            for (int k = 0; k <= 4; k += 2)
            begin
                if (!(i == 2 && k == 2) && w[i][k] == CELL_UNDEF)
                begin
                    undef_near = 1'b1;
                end
            end
        end
        ring = (r >= DIM_W'(2)) && (r <= eff_h - DIM_W'(3)) &&
               (c >= DIM_W'(2)) && (c <= eff_w - DIM_W'(3)) &&
               ((r == DIM_W'(2)) || (r == eff_h - DIM_W'(3)) ||
                (c == DIM_W'(2)) || (c == eff_w - DIM_W'(3)));
        eval = tap.valid && (tap.k == 3'd4) && (tap.col >= DIM_W'(3));
        if (n == 4'd3 && center == CELL_DEAD)
        begin
            nx_wdata = CELL_LIVE;
        end
        else if (n == 4'd2 || n == 4'd3)
        begin
            nx_wdata = center;
        end
        else
        begin
            nx_wdata = CELL_DEAD;
        end
    end

    assign nx_we   = eval;
    assign nx_addr = {tap.row, c[COL_W-1:0]};
    assign hit     = eval && ring && (center == CELL_LIVE) && undef_near;

endmodule

/* src/life_tile_generation_unit.sv */
// Life tile generation unit: one Conway Life tile (B3/S23) of up to 64x64 cells with a halo.
// Cell reads return the registered output of the cell memory; a clear rewrites the H x W area. A generation
// sweeps the interior rows with a 5x5 window fed from the single cell memory read port,
// five reads per column over W+1 columns of each of H-2 rows, then copies the interior back
// from the next-state memory. After reset a clearing pass over the full 64x64 memory runs
// before the first item is taken.
module life_tile_generation_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ltg_pkg::DIM_W-1:0]     cfg_data,
    ltg_in_if.sink                        in,
    ltg_out_if.source                     out
);
    import ltg_pkg::*;

    ltg_state_t state_reg, state_next;
    logic [DIM_W-1:0] height_reg, width_reg;
    logic [DIM_W-1:0] eff_h, eff_w, lim_h, lim_w;

    logic [ROW_W-1:0] sr_reg, sr_next;
    logic [COL_W-1:0] sc_reg, sc_next;
    logic [2:0]       gk_reg, gk_next;
    logic [DIM_W-1:0] gj_reg, gj_next;
    logic             rd_inside_reg;
    logic             resize_reg;
    ltg_tap_t         tap_reg, tap_next;
    logic             cp_valid_reg;
    logic [ADDR_W-1:0] cp_addr_reg;

    logic out_valid_reg;
    cell_t out_rd_reg;
    logic out_rq_reg;

    logic acc, in_area, clr_last, gen_last, copy_last;
    logic [7:0] rr;
    logic out_load;
    cell_t out_rd_val;
    logic out_rq_val;

    logic             cell_we;
    logic [ADDR_W-1:0] cell_waddr, cell_raddr;
    cell_t            cell_wdata, cell_rdata;
    logic             nx_we, hit;
    logic [ADDR_W-1:0] nx_waddr;
    cell_t            nx_wdata, nx_rdata;
    cell_t            clr_val;

    assign eff_h = clamp_dim(height_reg, MAX_ROWS);
    assign eff_w = clamp_dim(width_reg, MAX_COLS);
    assign lim_h = (state_reg == ST_INIT) ? DIM_W'(MAX_ROWS) : eff_h;
    assign lim_w = (state_reg == ST_INIT) ? DIM_W'(MAX_COLS) : eff_w;

    assign in.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out.ready);
    assign acc      = in.valid && in.ready;
    assign in_area  = ({1'b0, in.row} < eff_h) && ({1'b0, in.col} < eff_w);

    // Sweep end conditions.
    assign clr_last  = ({1'b0, sr_reg} == lim_h - DIM_W'(1)) &&
                       ({1'b0, sc_reg} == lim_w - DIM_W'(1));
    assign gen_last  = (gk_reg == 3'd4) && (gj_reg == eff_w) &&
                       ({1'b0, sr_reg} == eff_h - DIM_W'(2));
    assign copy_last = ({1'b0, sr_reg} == eff_h - DIM_W'(2)) &&
                       ({1'b0, sc_reg} == eff_w - DIM_W'(2));

    // Row of the current window read: the center row offset by k-2.
    assign rr = {2'b00, sr_reg} + {5'b00000, gk_reg} - 8'd2;

    // Clear value: border on the edge of the area in use, dead elsewhere.
    always_comb
    begin
        clr_val = CELL_DEAD;
        if (({1'b0, sr_reg} < eff_h) && ({1'b0, sc_reg} < eff_w) &&
            (sr_reg == '0 || {1'b0, sr_reg} == eff_h - DIM_W'(1) ||
             sc_reg == '0 || {1'b0, sc_reg} == eff_w - DIM_W'(1)))
        begin
            clr_val = CELL_BORDER;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (in.op)
                        OP_READ:  state_next = ST_READ;
                        OP_GEN:   state_next = ST_GEN;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:     state_next = ST_IDLE;
            ST_CLEAR:
            begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_GEN:
            begin
                if (gen_last) state_next = ST_GEN_END;
            end
            ST_GEN_END:  state_next = ST_COPY;
            ST_COPY:
            begin
                if (copy_last) state_next = ST_COPY_END;
            end
            ST_COPY_END: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Memory controls, sweep counters and result loading.
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = {in.row, in.col};
        cell_wdata = in.cell_value;
        cell_raddr = {in.row, in.col};
        out_load   = 1'b0;
        out_rd_val = CELL_DEAD;
        out_rq_val = 1'b0;
        sr_next    = sr_reg;
        sc_next    = sc_reg;
        gk_next    = gk_reg;
        gj_next    = gj_reg;
        tap_next   = '0;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = {sr_reg, sc_reg};
                cell_wdata = clr_val;
                if ({1'b0, sc_reg} == lim_w - DIM_W'(1))
                begin
                    sc_next = '0;
                    sr_next = sr_reg + ROW_W'(1);
                end
                else
                begin
                    sc_next = sc_reg + COL_W'(1);
                end
                if (clr_last && state_reg == ST_CLEAR)
                begin
                    out_load = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (in.op)
                        OP_WRITE:
                        begin
                            cell_we  = in_area;
                            out_load = 1'b1;
                        end
                        OP_GEN:
                        begin
                            sr_next = ROW_W'(1);
                            gj_next = '0;
                            gk_next = '0;
                        end
                        default:
                        begin
                            sr_next = '0;
                            sc_next = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_load   = 1'b1;
                out_rd_val = rd_inside_reg ? cell_rdata : CELL_DEAD;
            end
            ST_GEN:
            begin
                cell_raddr     = {rr[ROW_W-1:0], gj_reg[COL_W-1:0]};
                tap_next.valid = 1'b1;
                tap_next.k     = gk_reg;
                tap_next.row   = sr_reg;
                tap_next.col   = gj_reg;
                tap_next.mask  = !rr[7] && (rr[DIM_W-1:0] < eff_h) && (gj_reg < eff_w);
                if (gk_reg == 3'd4)
                begin
                    gk_next = '0;
                    if (gj_reg == eff_w)
                    begin
                        gj_next = '0;
                        sr_next = sr_reg + ROW_W'(1);
                    end
                    else
                    begin
                        gj_next = gj_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    gk_next = gk_reg + 3'd1;
                end
            end
            ST_GEN_END:
            begin
                sr_next = ROW_W'(1);
                sc_next = COL_W'(1);
            end
            ST_COPY:
            begin
                if ({1'b0, sc_reg} == eff_w - DIM_W'(2))
                begin
                    sc_next = COL_W'(1);
                    sr_next = sr_reg + ROW_W'(1);
                end
                else
                begin
                    sc_next = sc_reg + COL_W'(1);
                end
            end
            ST_COPY_END:
            begin
                out_load   = 1'b1;
                out_rq_val = resize_reg;
            end
            default:
            begin
            end
        endcase
        // Copy write-back lands in the cycle after its read.
        if (cp_valid_reg)
        begin
            cell_we    = 1'b1;
            cell_waddr = cp_addr_reg;
            cell_wdata = nx_rdata;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            height_reg    <= DIM_W'(MIN_DIM);
            width_reg     <= DIM_W'(MIN_DIM);
            sr_reg        <= '0;
            sc_reg        <= '0;
            gk_reg        <= '0;
            gj_reg        <= '0;
            tap_reg       <= '0;
            cp_valid_reg  <= 1'b0;
            resize_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sr_reg       <= sr_next;
            sc_reg       <= sc_next;
            gk_reg       <= gk_next;
            gj_reg       <= gj_next;
            tap_reg      <= tap_next;
            cp_valid_reg <= (state_reg == ST_COPY);
            if (cfg_we && cfg_index == REG_GRID_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_GRID_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (acc && in.op == OP_GEN)
            begin
                resize_reg <= 1'b0;
            end
            else if (hit)
            begin
                resize_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cp_addr_reg <= {sr_reg, sc_reg};
        if (acc)
        begin
            rd_inside_reg <= in_area;
        end
        if (out_load)
        begin
            out_rd_reg <= out_rd_val;
            out_rq_reg <= out_rq_val;
        end
    end

    assign out.valid          = out_valid_reg;
    assign out.read_value     = out_rd_reg;
    assign out.resize_request = out_rq_reg;

    // Current tile.
    ltg_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // Next-generation tile.
    ltg_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr ({sr_reg, sc_reg}),
        .rdata (nx_rdata)
    );

    // Window and rule evaluation.
    ltg_window u_window (
        .clk      (clk),
        .tap      (tap_reg),
        .rdata    (cell_rdata),
        .eff_h    (eff_h),
        .eff_w    (eff_w),
        .nx_we    (nx_we),
        .nx_addr  (nx_waddr),
        .nx_wdata (nx_wdata),
        .hit      (hit)
    );

    // Items are taken only from idle, with room for the result.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready |-> (state_reg == ST_IDLE) && (!out_valid_reg || out.ready))
        else $error("item taken outside idle");

    // Window returns belong to a generation sweep.
    a_tap_gen: assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg.valid |-> (state_reg == ST_GEN || state_reg == ST_GEN_END))
        else $error("window return outside generation");

    // The current tile is not modified while a generation reads it.
    a_no_write_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN) |-> !cell_we)
        else $error("tile written during generation sweep");

endmodule
